@@ sv/tksl_pkg.sv @@
// shared constants and types for the top-k score list
`timescale 1ns / 1ps

package tksl_pkg;

    localparam int MAX_KEEP = 16;
    localparam int TAG_BITS = 16;
    localparam int SCORE_W  = 32;
    localparam int TAG_IN_W = 16;
    localparam int KEEP_W   = 5;
    localparam int RANK_W   = 4;
    localparam int IDX_W    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CNT_W    = $clog2(MAX_KEEP + 1);
    localparam int IN_W     = 48;
    localparam int OUT_W    = 64;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic                       load;
        logic                       accepted;
        logic signed [SCORE_W-1:0]  cand_score;
        logic [TAG_BITS-1:0]        cand_tag;
    } cell_ctl_t;

    // what a cell shows its right-hand neighbor
    typedef struct packed {
        logic                       ge;
        logic signed [SCORE_W-1:0]  score;
        logic [TAG_BITS-1:0]        tag;
    } cell_dat_t;

endpackage

@@ sv/tksl_cell.sv @@
// one list slot: holds an entry, compares it to the candidate, shifts right on insert
`timescale 1ns / 1ps

module tksl_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  tksl_pkg::cell_ctl_t ctl,
    input  logic               valid,
    input  tksl_pkg::cell_dat_t prev,
    output tksl_pkg::cell_dat_t cur
);
    import tksl_pkg::*;

    logic signed [SCORE_W-1:0] score_reg;
    logic signed [SCORE_W-1:0] score_next;
    logic [TAG_BITS-1:0]       tag_reg;
    logic [TAG_BITS-1:0]       tag_next;
    logic                      ge;

    // held entry ranks ahead of the candidate (ties keep arrival order)
    assign ge = valid && (score_reg >= ctl.cand_score);

    assign cur.ge    = ge;
    assign cur.score = score_reg;
    assign cur.tag   = tag_reg;

    // keep, take the candidate, or take the left neighbor's entry
    always_comb
    begin
        score_next = score_reg;
        tag_next   = tag_reg;
        if (ctl.load && ctl.accepted && !ge)
        begin
            if (prev.ge)
            begin
                score_next = ctl.cand_score;
                tag_next   = ctl.cand_tag;
            end
            else
            begin
                score_next = prev.score;
                tag_next   = prev.tag;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg <= '0;
            tag_reg   <= '0;
        end
        else
        begin
            score_reg <= score_next;
            tag_reg   <= tag_next;
        end
    end

endmodule

@@ sv/top_k_score_list_top.sv @@
// top level: config register, cell chain, fill count and result word register
//
// channel    direction  word contents (low bit up)
// s_axis     in         cand_score[31:0], cand_tag[47:32]
// m_axis     out        accepted, rank, evicted, evicted_tag, lowest_score, kept, full_res
// cfg        in         keep_count[4:0]
//
// one candidate per cycle while s_axis_tready is high: the whole cell row compares and shifts in the same edge
// the result word is registered at the edge that takes its candidate and is out from the next cycle
// s_axis_tready drops only while a result waits and m_axis_tready is low
// reset clears fill count, result valid and the cell entries; keep_count resets to 1
`timescale 1ns / 1ps

module top_k_score_list_top
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [tksl_pkg::IN_W-1:0] s_axis_tdata,   // cand_score, cand_tag
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [tksl_pkg::OUT_W-1:0] m_axis_tdata,  // accepted, rank[4:1], evicted,
                                                      // evicted_tag[21:6], lowest_score[53:22],
                                                      // kept[58:54], full_res, zero pad
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [tksl_pkg::KEEP_W-1:0] cfg_data    // keep_count
);
    import tksl_pkg::*;

    logic [KEEP_W-1:0]         keep_reg;
    logic [CNT_W-1:0]          fill_reg;
    logic [CNT_W-1:0]          fill_next;
    logic                      out_valid_reg;
    logic [OUT_W-1:0]          out_data_reg;
    logic [OUT_W-1:0]          out_data_next;

    logic                      take;
    logic signed [SCORE_W-1:0] cand_score;
    logic [TAG_IN_W-1:0]       cand_tag_in;
    logic [CNT_W-1:0]          k_eff;
    logic [CNT_W-1:0]          f_eff;
    logic [MAX_KEEP-1:0]       ge_vec;
    logic [CNT_W-1:0]          pos;
    logic                      accepted;
    logic                      evicted;
    logic [TAG_IN_W-1:0]       evicted_tag;
    logic signed [SCORE_W-1:0] lowest;
    logic [CNT_W-1:0]          low_sel;
    logic [CNT_W-1:0]          evict_sel;
    logic                      full_res;

    cell_ctl_t                 ctl;
    cell_dat_t                 chain_in  [MAX_KEEP];
    cell_dat_t                 chain_out [MAX_KEEP];

    assign cand_score  = s_axis_tdata[SCORE_W-1:0];
    assign cand_tag_in = s_axis_tdata[SCORE_W +: TAG_IN_W];

    assign cfg_ready     = 1'b1;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // effective keep count saturates, fill is cut to it at the start of a step
    always_comb
    begin
        if (32'(keep_reg) > 32'(MAX_KEEP))
            k_eff = CNT_W'(MAX_KEEP);
        else
            k_eff = CNT_W'(keep_reg);
        f_eff = (fill_reg > k_eff) ? k_eff : fill_reg;
    end

    assign ctl.load       = take;
    assign ctl.accepted   = accepted;
    assign ctl.cand_score = cand_score;
    assign ctl.cand_tag   = TAG_BITS'(cand_tag_in);

    // cell row, each slot fed by its left neighbor; slot 0 sees the candidate
    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEEP; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign chain_in[gi].ge    = 1'b1;
                assign chain_in[gi].score = cand_score;
                assign chain_in[gi].tag   = TAG_BITS'(cand_tag_in);
            end
            else
            begin : g_link
                assign chain_in[gi] = chain_out[gi-1];
            end

            tksl_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .valid (CNT_W'(gi) < f_eff),
                .prev  (chain_in[gi]),
                .cur   (chain_out[gi])
            );

            assign ge_vec[gi] = chain_out[gi].ge;
        end
    endgenerate

    // insert position: first slot that does not rank ahead (ge flags form a prefix)
    always_comb
    begin
        pos = CNT_W'(MAX_KEEP);
        for (int i = MAX_KEEP - 1; i >= 0; i--)
        begin
            if (!ge_vec[i])
                pos = CNT_W'(i);
        end
    end

    // outcome, new fill and the values picked from the old row
    always_comb
    begin
        accepted  = pos < k_eff;
        evicted   = accepted && (f_eff == k_eff);
        evict_sel = k_eff - CNT_W'(1);
        if (evicted)
            evicted_tag = TAG_IN_W'(chain_out[evict_sel[IDX_W-1:0]].tag);
        else
            evicted_tag = '0;

        if (accepted && !evicted)
            fill_next = f_eff + CNT_W'(1);
        else
            fill_next = f_eff;

        // last entry after the step: candidate, or an old entry maybe shifted by one
        if (accepted)
            low_sel = fill_next - CNT_W'(2);
        else
            low_sel = f_eff - CNT_W'(1);

        if (fill_next == '0)
            lowest = '0;
        else if (accepted && (pos == fill_next - CNT_W'(1)))
            lowest = cand_score;
        else
            lowest = chain_out[low_sel[IDX_W-1:0]].score;

        full_res = (fill_next == k_eff);

        out_data_next = '0;
        out_data_next[0]     = accepted;
        out_data_next[4:1]   = accepted ? RANK_W'(pos) : '0;
        out_data_next[5]     = evicted;
        out_data_next[21:6]  = evicted_tag;
        out_data_next[53:22] = lowest;
        out_data_next[58:54] = 5'(fill_next);
        out_data_next[59]    = full_res;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg      <= KEEP_W'(1);
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                keep_reg <= cfg_data;
            if (take)
            begin
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (take)
            out_data_reg <= out_data_next;
    end

endmodule

@@ sv/tksl_checker.sv @@
// port-level checks for the top-k score list, bound to the top level
`timescale 1ns / 1ps

module tksl_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [tksl_pkg::OUT_W-1:0] m_axis_tdata
);
    import tksl_pkg::*;

    // a taken candidate always yields a result word next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("no result after accepted candidate");

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // fill never exceeds the list depth
    a_kept_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[58:54]) <= 32'(MAX_KEEP))
        else $error("kept above list depth");

    // a dropped candidate has rank zero and evicts nothing
    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[4:1] == '0 && !m_axis_tdata[5])
        else $error("dropped candidate reports rank or eviction");

    // an eviction only happens on a full list
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[59] && m_axis_tdata[58:54] != '0)
        else $error("eviction without a full list");

endmodule

bind top_k_score_list_top tksl_checker u_tksl_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ bench/tb_top_k_score_list_top.sv @@
// self-checking testbench for the top-k score list with its own ranking predictor
`timescale 1ns / 1ps

module tb_top_k_score_list_top;

    import tksl_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    // one offered candidate, laid out as on the input word (score in the low bits)
    typedef struct packed {
        logic [TAG_IN_W-1:0]       tag;
        logic signed [SCORE_W-1:0] score;
    } cand_t;

    // one result word, unpacked
    typedef struct packed {
        logic                      accepted;
        logic [RANK_W-1:0]         rank;
        logic                      evicted;
        logic [TAG_IN_W-1:0]       evicted_tag;
        logic signed [SCORE_W-1:0] lowest;
        logic [KEEP_W-1:0]         kept;
        logic                      full;
    } outcome_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [KEEP_W-1:0]   cfg_data = '0;

    // predictor state: the held list and the keep register as the block sees it
    logic signed [SCORE_W-1:0] held_score [MAX_KEEP];
    logic [TAG_BITS-1:0]       held_tag   [MAX_KEEP];
    int                        held_count = 0;
    logic [KEEP_W-1:0]         keep_setting = 5'd1;

    cand_t    pending_cands[$];
    outcome_t expected_outcomes[$];

    // sender burst shape, set per phase; zero burst_max means no gaps
    int burst_max = 0;
    int gap_max = 0;
    int burst_left = 0;
    int gap_left = 0;

    // receiver stall pattern
    logic [15:0] ready_pattern = 16'hFFFF;
    int          ready_phase = 0;

    int items_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int evictions_seen = 0;
    int drops_seen = 0;
    int keep_writes = 0;
    int idle_cycles = 0;
    int run_score = 0;

    top_k_score_list_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // cand_score, cand_tag
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // accepted, rank, evicted, evicted_tag,
                                          // lowest_score, kept, full_res
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)         // keep_count
    );

    always #5 clk = ~clk;

    // sorted insert of one candidate into the predicted list
    function automatic outcome_t insert_candidate(cand_t c);
        outcome_t r;
        int       limit;
        int       pos;
        int       i;
        r = '0;
        limit = (keep_setting > MAX_KEEP) ? MAX_KEEP : int'(keep_setting);
        // a lowered keep count silently trims the tail
        if (held_count > limit)
            held_count = limit;
        pos = 0;
        while (pos < held_count && held_score[pos] >= c.score)
            pos++;
        if (pos < limit)
        begin
            r.accepted = 1'b1;
            r.rank = pos[RANK_W-1:0];
            if (held_count == limit)
            begin
                r.evicted = 1'b1;
                r.evicted_tag = held_tag[limit-1];
                held_count = limit - 1;
            end
            for (i = held_count; i > pos; i--)
            begin
                held_score[i] = held_score[i-1];
                held_tag[i] = held_tag[i-1];
            end
            held_score[pos] = c.score;
            held_tag[pos] = c.tag[TAG_BITS-1:0];
            held_count++;
        end
        r.lowest = (held_count > 0) ? held_score[held_count-1] : '0;
        r.kept = held_count[KEEP_W-1:0];
        r.full = (held_count == limit);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in result %0d, %s: expected %0h, got %0h",
                         results_seen, name, want, seen);
        end
    endfunction

    // input side: bursts and gaps, prediction on every accepted word
    always @(posedge clk)
    begin
        cand_t c;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                c = s_axis_tdata;
                expected_outcomes.push_back(insert_candidate(c));
                items_sent++;
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_cands.size() > 0)
                begin
                    s_axis_tdata <= pending_cands.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (burst_max > 0)
                    begin
                        burst_left--;
                        if (burst_left <= 0)
                        begin
                            burst_left = $urandom_range(1, burst_max);
                            gap_left = $urandom_range(1, gap_max);
                        end
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side: ready follows a stall pattern that is redrawn at random, sometimes all ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            ready_phase <= ready_phase + 1;
            if (ready_phase % 64 == 63)
                ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                            : 16'($urandom());
            m_axis_tready <= ready_pattern[ready_phase % 16];
        end
    end

    // result checker
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.accepted = m_axis_tdata[0];
            got.rank = m_axis_tdata[4:1];
            got.evicted = m_axis_tdata[5];
            got.evicted_tag = m_axis_tdata[21:6];
            got.lowest = m_axis_tdata[53:22];
            got.kept = m_axis_tdata[58:54];
            got.full = m_axis_tdata[59];
            if (expected_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing expected: %0h",
                             results_seen, m_axis_tdata);
            end
            else
            begin
                want = expected_outcomes.pop_front();
                check_field("accepted", want.accepted, got.accepted);
                check_field("rank", want.rank, got.rank);
                check_field("evicted", want.evicted, got.evicted);
                check_field("evicted_tag", want.evicted_tag, got.evicted_tag);
                check_field("lowest_score", want.lowest, got.lowest);
                check_field("kept", want.kept, got.kept);
                check_field("full_res", want.full, got.full);
                if (want.evicted)
                    evictions_seen++;
                if (!want.accepted)
                    drops_seen++;
            end
            results_seen++;
        end
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("no word moved for %0d cycles", IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic offer(input logic signed [SCORE_W-1:0] score, input logic [15:0] tag);
        cand_t c;
        c.score = score;
        c.tag = tag;
        pending_cands.push_back(c);
    endtask

    // hold off until the block has nothing in flight
    task automatic wait_drained();
        while (pending_cands.size() > 0 || s_axis_tvalid || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_keep(input logic [KEEP_W-1:0] value);
        wait_drained();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        keep_setting = value;
        keep_writes++;
    endtask

    // random candidates: wide, narrow with ties, extremes, rising and falling runs
    task automatic offer_random(input int count);
        logic signed [SCORE_W-1:0] s;
        int                        n;
        for (n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: s = $urandom();
                4, 5, 6:    s = $signed($urandom_range(0, 16)) - 8;
                7:
                    case ($urandom_range(0, 5))
                        0: s = 32'sh8000_0000;
                        1: s = 32'sh7FFF_FFFF;
                        2: s = 32'sh8000_0001;
                        3: s = 32'sh7FFF_FFFE;
                        4: s = 0;
                        default: s = -1;
                    endcase
                8:
                begin
                    run_score = run_score + $urandom_range(0, 3);
                    s = run_score;
                end
                default:
                begin
                    run_score = run_score - $urandom_range(0, 3);
                    s = run_score;
                end
            endcase
            offer(s, 16'($urandom()));
        end
    endtask

    // stimulus sequence
    initial
    begin
        logic [KEEP_W-1:0] plan [12];
        int                p;
        plan = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd1, 5'd17, 5'd8, 5'd16, 5'd2, 5'd5, 5'd12, 5'd16};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset keep count of one: replace, ties dropped, extremes
        offer(0, 16'h0000);
        offer(-1, 16'hFFFF);
        offer(0, 16'h0001);
        offer(32'sh7FFF_FFFF, 16'hFFFF);
        offer(32'sh8000_0000, 16'h1234);
        // keep four: ties in arrival order, eviction, drop beyond the end
        write_keep(5'd4);
        offer(5, 16'h0010);
        offer(5, 16'h0011);
        offer(5, 16'h0012);
        offer(7, 16'h0013);
        offer(5, 16'h0014);
        offer(100, 16'h0015);
        offer(32'sh8000_0000, 16'h0016);
        offer(32'sh7FFF_FFFF, 16'hFFFF);
        offer(-3, 16'h0000);
        // lowering below the fill trims silently
        write_keep(5'd2);
        offer(6, 16'h0020);
        offer(200, 16'h0021);
        // keep zero drops everything
        write_keep(5'd0);
        offer(32'sh7FFF_FFFF, 16'hFFFF);
        offer(32'sh8000_0000, 16'h0000);
        // above the maximum saturates
        write_keep(5'd31);
        offer(1, 16'h0030);
        offer(-1, 16'h0031);

        // random phases, alternating smooth and bursty traffic
        for (p = 0; p < 12; p++)
        begin
            write_keep(plan[p]);
            burst_max = (p % 2 == 0) ? 0 : $urandom_range(2, 12);
            gap_max = $urandom_range(1, 6);
            burst_left = 1;
            gap_left = 0;
            run_score = $signed($urandom_range(0, 40)) - 20;
            offer_random(60);
            // let everything drain mid-phase before carrying on
            if (p % 3 == 1)
                wait_drained();
            offer_random(65);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("%0d candidates, %0d results checked over %0d keep count writes",
                 items_sent, results_seen, keep_writes);
        $display("%0d evictions and %0d drops predicted, %0d mismatches",
                 evictions_seen, drops_seen, mismatches);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
